// ----- rtl/dlbc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dlbc_pkg;

    // Item kinds and targets
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_COMMAND = 1'b1;
    localparam logic TGT_RGB    = 1'b0;
    localparam logic TGT_IND    = 1'b1;

    // RGB commands
    localparam logic [1:0] RGB_SET_COLOR = 2'd0;
    localparam logic [1:0] RGB_BLINK     = 2'd1;
    localparam logic [1:0] RGB_STOP      = 2'd2;
    localparam logic [1:0] RGB_IGNORED   = 2'd3;

    // Indicator commands
    localparam logic [1:0] IND_ON    = 2'd0;
    localparam logic [1:0] IND_OFF   = 2'd1;
    localparam logic [1:0] IND_BLINK = 2'd2;
    localparam logic [1:0] IND_STOP  = 2'd3;

    // Register indexes (paddr[2])
    localparam logic REG_DEFAULT_INTERVAL = 1'b0;
    localparam logic REG_IND_POLARITY     = 1'b1;

    localparam logic [15:0] RESET_PERIOD_MS = 16'd1000;
    localparam logic [23:0] DARK_COLOR      = 24'h000000;

    typedef struct packed {
        logic        blinking;
        logic [15:0] period;
        logic [15:0] left;
        logic        phase_on;
        logic [14:0] countdown;
    } blinker_t;

    localparam blinker_t BLINKER_RESET = '{
        blinking:  1'b0,
        period:    RESET_PERIOD_MS,
        left:      16'd0,
        phase_on:  1'b0,
        countdown: 15'd0
    };

    // Half period, raised to one tick when it would be zero
    function automatic logic [14:0] half_of(input logic [15:0] period);
        logic [14:0] h;
        h = period[15:1];
        return (h == 15'd0) ? 15'd1 : h;
    endfunction

    // Begin a blink in the on phase
    function automatic blinker_t blink_start(
        input logic [15:0] interval,
        input logic [15:0] count,
        input logic [15:0] default_interval
    );
        blinker_t b;
        b.blinking  = 1'b1;
        b.period    = (interval == 16'd0) ? default_interval : interval;
        b.left      = count;
        b.phase_on  = 1'b1;
        b.countdown = half_of(b.period);
        return b;
    endfunction

    // Leave blink mode with the given lit state
    function automatic blinker_t go_steady(input blinker_t b_in, input logic lit);
        blinker_t b;
        b          = b_in;
        b.blinking = 1'b0;
        b.phase_on = lit;
        return b;
    endfunction

    // Advance one millisecond
    function automatic blinker_t blink_tick(input blinker_t b_in);
        blinker_t b;
        b = b_in;
        if (b.blinking) begin
            if (b.countdown > 15'd1) begin
                b.countdown = b.countdown - 15'd1;
            end else begin
                b.phase_on  = !b.phase_on;
                b.countdown = half_of(b.period);
                if ((b.left != 16'd0) && !b.phase_on) begin
                    b.left = b.left - 16'd1;
                    if (b.left == 16'd0) begin
                        b.blinking  = 1'b0;
                        b.phase_on  = 1'b0;
                        b.countdown = 15'd0;
                    end
                end
            end
        end
        return b;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/dual_led_blink_controller_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Each item passes through the input register, then the result register. Throughput: one
// item per cycle while out_stall does not hold the result; the LED state update is a single step.
// A waiting result does not block intake while the input register is free.
// Reset (rst_n low, asynchronous): both LEDs steady and dark, periods 1000 ms,
// default interval 1000 ms, indicator active high, pipeline empty.
module dual_led_blink_controller_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        operation,
    input  wire logic        target,
    input  wire logic [1:0]  command,
    input  wire logic [23:0] color,
    input  wire logic [15:0] interval_ms,
    input  wire logic [15:0] count,
    // Result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [23:0]      rgb_drive,
    output logic             indicator_pin,
    output logic             rgb_blinking,
    output logic             indicator_blinking,
    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // Configuration registers
    logic [15:0] default_interval_reg;
    logic        ind_active_high_reg;

    // Input register
    logic        s1_valid_reg;
    logic        s1_op_reg;
    logic        s1_target_reg;
    logic [1:0]  s1_cmd_reg;
    logic [23:0] s1_color_reg;
    logic [15:0] s1_interval_reg;
    logic [15:0] s1_count_reg;

    // LED state
    dlbc_pkg::blinker_t rgb_reg, rgb_next;
    dlbc_pkg::blinker_t ind_reg, ind_next;
    logic [23:0] rgb_shown_reg, rgb_shown_next;
    logic [23:0] rgb_blink_color_reg, rgb_blink_color_next;

    // Result register
    logic        out_valid_reg;
    logic [23:0] rgb_drive_reg;
    logic        ind_pin_reg;
    logic        rgb_blinking_reg;
    logic        ind_blinking_reg;

    logic advance;
    logic s1_load;
    logic cfg_write;

    // Pipeline moves when the result register is free or being taken
    assign advance  = !out_valid_reg || !out_stall;
    assign s1_load  = !s1_valid_reg || advance;
    assign in_stall = !s1_load;

    // Configuration access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[2])
            dlbc_pkg::REG_DEFAULT_INTERVAL: prdata = {16'd0, default_interval_reg};
            dlbc_pkg::REG_IND_POLARITY:     prdata = {31'd0, ind_active_high_reg};
            default:                        prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_interval_reg <= dlbc_pkg::RESET_PERIOD_MS;
            ind_active_high_reg  <= 1'b1;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == dlbc_pkg::REG_DEFAULT_INTERVAL)
            begin
                default_interval_reg <= pwdata[15:0];
            end
            else
            begin
                ind_active_high_reg <= pwdata[0];
            end
        end
    end

    // Capture the input item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_load)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && in_valid)
        begin
            s1_op_reg       <= operation;
            s1_target_reg   <= target;
            s1_cmd_reg      <= command;
            s1_color_reg    <= color;
            s1_interval_reg <= interval_ms;
            s1_count_reg    <= count;
        end
    end

    // Apply the item to the LED state
    always_comb
    begin
        rgb_next             = rgb_reg;
        ind_next             = ind_reg;
        rgb_shown_next       = rgb_shown_reg;
        rgb_blink_color_next = rgb_blink_color_reg;

        if (s1_op_reg == dlbc_pkg::OP_TICK)
        begin
            if (rgb_reg.blinking)
            begin
                rgb_next       = dlbc_pkg::blink_tick(rgb_reg);
                rgb_shown_next = rgb_next.phase_on ? rgb_blink_color_reg
                                                   : dlbc_pkg::DARK_COLOR;
            end
            ind_next = dlbc_pkg::blink_tick(ind_reg);
        end
        else if (s1_target_reg == dlbc_pkg::TGT_RGB)
        begin
            unique case (s1_cmd_reg)
                dlbc_pkg::RGB_SET_COLOR:
                begin
                    rgb_next       = dlbc_pkg::go_steady(rgb_reg, 1'b0);
                    rgb_shown_next = s1_color_reg;
                end
                dlbc_pkg::RGB_BLINK:
                begin
                    rgb_next = dlbc_pkg::blink_start(s1_interval_reg, s1_count_reg,
                                                     default_interval_reg);
                    rgb_blink_color_next = s1_color_reg;
                    rgb_shown_next       = s1_color_reg;
                end
                dlbc_pkg::RGB_STOP:
                begin
                    rgb_next       = dlbc_pkg::go_steady(rgb_reg, 1'b0);
                    rgb_shown_next = dlbc_pkg::DARK_COLOR;
                end
                default:
                begin
                    rgb_next = rgb_reg;
                end
            endcase
        end
        else
        begin
            unique case (s1_cmd_reg) inside
                dlbc_pkg::IND_ON:
                begin
                    ind_next = dlbc_pkg::go_steady(ind_reg, 1'b1);
                end
                dlbc_pkg::IND_OFF, dlbc_pkg::IND_STOP:
                begin
                    ind_next = dlbc_pkg::go_steady(ind_reg, 1'b0);
                end
                default:
                begin
                    ind_next = dlbc_pkg::blink_start(s1_interval_reg, s1_count_reg,
                                                     default_interval_reg);
                end
            endcase
        end
    end

    // Hold state until an item reaches the result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rgb_reg             <= dlbc_pkg::BLINKER_RESET;
            ind_reg             <= dlbc_pkg::BLINKER_RESET;
            rgb_shown_reg       <= dlbc_pkg::DARK_COLOR;
            rgb_blink_color_reg <= dlbc_pkg::DARK_COLOR;
            out_valid_reg       <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                rgb_reg             <= rgb_next;
                ind_reg             <= ind_next;
                rgb_shown_reg       <= rgb_shown_next;
                rgb_blink_color_reg <= rgb_blink_color_next;
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            rgb_drive_reg    <= rgb_shown_next;
            ind_pin_reg      <= (ind_next.phase_on == ind_active_high_reg);
            rgb_blinking_reg <= rgb_next.blinking;
            ind_blinking_reg <= ind_next.blinking;
        end
    end

    assign out_valid          = out_valid_reg;
    assign rgb_drive          = rgb_drive_reg;
    assign indicator_pin      = ind_pin_reg;
    assign rgb_blinking       = rgb_blinking_reg;
    assign indicator_blinking = ind_blinking_reg;

endmodule

`default_nettype wire
